>>> src/compass_heading_averager_defines.svh
// ----------------------------------------------------------------------------
// Compass heading averager assertion macros
// Implication checks on the block clock, disabled while reset is held low.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_AVERAGER_DEFINES_SVH
`define COMPASS_HEADING_AVERAGER_DEFINES_SVH

`ifndef SYNTHESIS
`define CHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("compass heading averager check failed");
`define CHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("compass heading averager check failed");
`else
`define CHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/cha_pkg.sv
// ----------------------------------------------------------------------------
// Compass heading averager package
// Fixed widths, angle constants, the arctangent table and the control states.
// ----------------------------------------------------------------------------
`default_nettype none

package cha_pkg;

	localparam int FIELD_W   = 16;
	localparam int XY_W      = 19;
	localparam int Z_W       = 31;
	localparam int WORK_FRAC = 20;
	localparam int TABLE_LEN = 24;
	localparam int STEP_W    = 5;
	localparam int SUM_W     = 24;
	localparam int CNT_W     = 8;
	localparam int OUT_W     = 16;
	localparam int DIV_CNT_W = 5;

	localparam logic signed [Z_W-1:0] DEG_90  = Z_W'(90 << WORK_FRAC);
	localparam logic signed [Z_W-1:0] DEG_180 = Z_W'(180 << WORK_FRAC);
	localparam logic signed [Z_W-1:0] DEG_270 = Z_W'(270 << WORK_FRAC);
	localparam logic signed [Z_W-1:0] DEG_360 = Z_W'(360 << WORK_FRAC);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ROTATE = 4'b0010,
		ST_ACCUM  = 4'b0100,
		ST_DIVIDE = 4'b1000
	} state_t;

	function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
		logic signed [Z_W-1:0] r;
		unique case (idx)
			5'd0:    r = Z_W'(47185920);
			5'd1:    r = Z_W'(27855475);
			5'd2:    r = Z_W'(14718068);
			5'd3:    r = Z_W'(7471121);
			5'd4:    r = Z_W'(3750058);
			5'd5:    r = Z_W'(1876857);
			5'd6:    r = Z_W'(938658);
			5'd7:    r = Z_W'(469358);
			5'd8:    r = Z_W'(234682);
			5'd9:    r = Z_W'(117342);
			5'd10:   r = Z_W'(58671);
			5'd11:   r = Z_W'(29335);
			5'd12:   r = Z_W'(14668);
			5'd13:   r = Z_W'(7334);
			5'd14:   r = Z_W'(3667);
			5'd15:   r = Z_W'(1833);
			5'd16:   r = Z_W'(917);
			5'd17:   r = Z_W'(458);
			5'd18:   r = Z_W'(229);
			5'd19:   r = Z_W'(115);
			5'd20:   r = Z_W'(57);
			5'd21:   r = Z_W'(29);
			5'd22:   r = Z_W'(14);
			5'd23:   r = Z_W'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/compass_heading_averager.sv
// ----------------------------------------------------------------------------
// Compass heading averager
// Iterative CORDIC heading from magnetometer X/Y, running sum over a
// configured number of samples, and a bit-serial divider for the mean.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Word contents
//  -------  ---------------------  ---------------------------------------
//  in       in_valid / in_ready    field_x, field_y (signed 16 bit)
//  out      out_valid / out_ready  mean_heading (unsigned, fraction bits)
//  cfg      cfg_valid / cfg_ready  cfg_data = samples_per_heading
//
//  An input word passes the accept state, min(CORDIC_STEPS, 24) CORDIC
//  rotations at one per cycle in the shared shift-and-add unit, and the
//  accumulate state; a word on an axis skips the rotations.
//  A word that completes a heading then goes through the radix-2 divider,
//  which develops one quotient bit per cycle while its last step is not held.
//  The result sits in an output register, so input words are taken while it
//  waits; only the last divider step holds while that register is occupied.
//  Reset is asynchronous and sets the FSM, sum, count, setting and valid flag;
//  the step and divider counters load before use, so there is no clearing pass.
`default_nettype none
`include "compass_heading_averager_defines.svh"

module compass_heading_averager #(
	parameter int ANGLE_FRACTION_BITS = 7,
	parameter int CORDIC_STEPS        = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] field_x,
	input  wire logic signed [15:0] field_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             mean_heading
);

	import cha_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int HEAD_W = ANGLE_FRACTION_BITS + 9;
	localparam int HEAD_LSB = WORK_FRAC - ANGLE_FRACTION_BITS;

	state_t                  state_q;
	logic [CNT_W-1:0]        spc_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [Z_W-1:0]   z_q;
	logic [STEP_W-1:0]       step_q;
	logic [SUM_W-1:0]        num_q;
	logic [CNT_W:0]          den_q;
	logic [CNT_W:0]          rem_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        mean_q;

	logic signed [XY_W-1:0]  x_in;
	logic signed [XY_W-1:0]  y_in;
	logic signed [XY_W-1:0]  x_sh;
	logic signed [XY_W-1:0]  y_sh;
	logic signed [Z_W-1:0]   ang;
	logic signed [Z_W-1:0]   folded;
	logic [HEAD_W-1:0]       head;
	logic [SUM_W-1:0]        sum_new;
	logic [CNT_W:0]          taken;
	logic [CNT_W:0]          target;
	logic                    emit;
	logic [CNT_W+1:0]        trial;
	logic                    q_bit;
	logic [CNT_W+1:0]        trial_sub;
	logic [SUM_W-1:0]        num_next;
	logic                    rot_last;
	logic                    div_last;
	logic                    div_go;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign mean_heading = mean_q;

	always_comb begin
		x_in = XY_W'(field_x);
		y_in = XY_W'(field_y);
		x_sh = x_q >>> step_q;
		y_sh = y_q >>> step_q;
		ang  = atan_deg(step_q);
		rot_last = (step_q == STEP_W'(STEPS - 1));

		if (z_q < 0) begin
			folded = z_q + DEG_360;
		end else if (z_q >= DEG_360) begin
			folded = z_q - DEG_360;
		end else begin
			folded = z_q;
		end
		head    = folded[HEAD_LSB +: HEAD_W];
		sum_new = sum_q + SUM_W'(head);
		taken   = {1'b0, cnt_q} + (CNT_W+1)'(1);
		target  = (spc_q == '0) ? (CNT_W+1)'(1) : {1'b0, spc_q};
		emit    = (taken >= target);

		trial     = {rem_q, num_q[SUM_W-1]};
		trial_sub = trial - {1'b0, den_q};
		q_bit     = (trial >= {1'b0, den_q});
		num_next  = {num_q[SUM_W-2:0], q_bit};
		div_last  = (div_cnt_q == DIV_CNT_W'(SUM_W - 1));
		div_go    = !(div_last && out_valid_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			spc_q       <= CNT_W'(1);
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				spc_q <= cfg_data;
			end
			out_valid_q <= (state_q == ST_DIVIDE && div_go && div_last) ||
				(out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (field_y == '0 || field_x == '0) begin
							state_q <= ST_ACCUM;
						end else begin
							state_q <= ST_ROTATE;
						end
					end
				end
				ST_ROTATE: begin
					if (rot_last) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					if (emit) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIVIDE;
					end else begin
						sum_q   <= sum_new;
						cnt_q   <= taken[CNT_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_DIVIDE: begin
					if (div_go && div_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				step_q <= '0;
				if (field_y == '0) begin
					z_q <= (field_x < 0) ? DEG_180 : '0;
				end else if (field_x == '0) begin
					z_q <= (field_y > 0) ? DEG_90 : DEG_270;
				end else if (field_x < 0) begin
					x_q <= -x_in;
					y_q <= -y_in;
					z_q <= DEG_180;
				end else begin
					x_q <= x_in;
					y_q <= y_in;
					z_q <= '0;
				end
			end
			ST_ROTATE: begin
				step_q <= step_q + STEP_W'(1);
				if (y_q > 0) begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + ang;
				end else begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - ang;
				end
			end
			ST_ACCUM: begin
				num_q     <= sum_new;
				den_q     <= taken;
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIVIDE: begin
				if (div_go) begin
					num_q     <= num_next;
					rem_q     <= q_bit ? trial_sub[CNT_W:0] : trial[CNT_W:0];
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						mean_q <= num_next[OUT_W-1:0];
					end
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	`CHA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`CHA_ASSERT_IMP(a_rem_below_den, clk, arst_n, state_q == ST_DIVIDE, rem_q < den_q)
	`CHA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, cnt_q != '1)
	`CHA_ASSERT_IMP(a_step_bound, clk, arst_n, state_q == ST_ROTATE,
		step_q < STEP_W'(STEPS))
	`CHA_ASSERT_NXT(a_emit_divides, clk, arst_n, state_q == ST_ACCUM && emit,
		state_q == ST_DIVIDE && sum_q == '0)

endmodule

`default_nettype wire

>>> tb/compass_heading_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading averager testbench
// Sends magnetometer words through the valid/ready input channel. A scoreboard
// class keeps its own CORDIC heading and running average and compares every
// returned mean heading word with the oldest expected one. Phases change the
// sample count register and the idle pattern of both channels.
// ----------------------------------------------------------------------------
module compass_heading_averager_tb;

	localparam int FRACTION_BITS = 7;
	localparam int ROTATIONS     = 16;
	localparam int ANGLE_SCALE   = 20;
	localparam int SETTLE_CYCLES = 60;

	localparam longint ARC_DEG [ROTATIONS] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
		938658, 469358, 234682, 117342, 58671, 29335,
		14668, 7334, 3667, 1833
	};

	class heading_ledger;
		bit [7:0]  samples_per_heading;
		bit [23:0] heading_sum;
		bit [7:0]  sample_count;
		bit [15:0] expected_headings[$];
		int        mismatches;
		int        samples_taken;
		int        headings_seen;

		function new();
			samples_per_heading = 8'd1;
			heading_sum = '0;
			sample_count = '0;
			mismatches = 0;
			samples_taken = 0;
			headings_seen = 0;
		endfunction

		function void set_samples(bit [7:0] value);
			samples_per_heading = value;
		endfunction

		function longint compass_angle(longint x, longint y);
			longint full_turn;
			longint z;
			longint xs;
			longint ys;
			full_turn = longint'(360) << ANGLE_SCALE;
			if (y == 0)
				return (x < 0) ? (longint'(180) << ANGLE_SCALE) : 0;
			if (x == 0)
				return (y > 0) ? (longint'(90) << ANGLE_SCALE) : (longint'(270) << ANGLE_SCALE);
			z = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = longint'(180) << ANGLE_SCALE;
			end
			for (int i = 0; i < ROTATIONS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ARC_DEG[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ARC_DEG[i];
				end
			end
			if (z < 0)
				z = z + full_turn;
			if (z >= full_turn)
				z = z - full_turn;
			return z;
		endfunction

		function void note_sample(bit signed [15:0] fx, bit signed [15:0] fy);
			longint      angle;
			bit [15:0]   heading;
			int unsigned target;
			int unsigned taken;
			angle = compass_angle(longint'(fx), longint'(fy));
			heading = 16'(angle >>> (ANGLE_SCALE - FRACTION_BITS));
			target = (samples_per_heading == 0) ? 1 : samples_per_heading;
			taken = sample_count + 1;
			samples_taken++;
			heading_sum = heading_sum + 24'(heading);
			if (taken >= target) begin
				expected_headings.push_back(16'(heading_sum / taken));
				heading_sum = '0;
				sample_count = '0;
			end else begin
				sample_count = 8'(taken);
			end
		endfunction

		function void check_heading(logic [15:0] actual);
			bit [15:0] wanted;
			headings_seen++;
			if (expected_headings.size() == 0) begin
				mismatches++;
				$error("mean_heading: expected none, actual %0d", actual);
				return;
			end
			wanted = expected_headings.pop_front();
			if (actual !== wanted) begin
				mismatches++;
				$error("mean_heading: expected %0d, actual %0d", wanted, actual);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [7:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic signed [15:0] field_x = '0;
	logic signed [15:0] field_y = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [15:0]       mean_heading;

	heading_ledger ledger = new();
	int send_idle_pct = 29;
	int recv_idle_pct = 82;
	int settings_written = 0;

	compass_heading_averager #(
		.ANGLE_FRACTION_BITS(FRACTION_BITS),
		.CORDIC_STEPS(ROTATIONS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.field_x(field_x),
		.field_y(field_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_heading(mean_heading)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready)
			ledger.check_heading(mean_heading);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_sample(input logic signed [15:0] fx, input logic signed [15:0] fy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		field_x <= fx;
		field_y <= fy;
		do @(posedge clk); while (in_ready !== 1'b1);
		ledger.note_sample(fx, fy);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.expected_headings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		ledger.set_samples(value);
		settings_written++;
	endtask

	function automatic logic signed [15:0] pick_field();
		int offset;
		offset = $urandom_range(0, 64) - 32;
		case ($urandom_range(0, 7))
			0: return 16'sd0;
			1: return 16'(offset);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_setting();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			default: return 8'($urandom_range(2, 12));
		endcase
	endfunction

	task automatic random_sample();
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		fx = pick_field();
		fy = pick_field();
		case ($urandom_range(0, 7))
			0: fy = fx;
			1: fy = -fx;
			default: ;
		endcase
		send_sample(fx, fy);
	endtask

	initial begin
		#2_000_000;
		$display("compass_heading_averager regression: fail");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_setting(8'd1);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		send_sample(16'sd0, -16'sd1);
		send_sample(16'sh7FFF, 16'sd0);
		send_sample(16'sh8000, 16'sd0);
		send_sample(16'sd0, 16'sh7FFF);
		send_sample(16'sd0, 16'sh8000);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sd1, -16'sd1);
		send_sample(-16'sd1, -16'sd1);
		send_sample(16'sh8000, 16'sd1);
		send_sample(16'sh8000, -16'sd1);
		send_sample(16'sd100, -16'sd1);
		settle();

		write_setting(8'd0);
		send_sample(-16'sd1, 16'sd1);
		send_sample(16'sd1, 16'sd1);
		settle();

		// Lowering the count with samples already summed closes the average early.
		write_setting(8'd255);
		send_sample(16'sd300, 16'sd20);
		send_sample(-16'sd5000, 16'sd7);
		send_sample(16'sd12, -16'sd31000);
		settle();
		write_setting(8'd2);
		send_sample(16'sh7FFF, -16'sd1);
		settle();

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				write_setting(pick_setting());
				repeat ($urandom_range(25, 45)) random_sample();
				settle();
			end
		end

		if (ledger.expected_headings.size() != 0) begin
			ledger.mismatches++;
			$error("mean_heading: %0d expected words never arrived",
				ledger.expected_headings.size());
		end
		$display("Run covered %0d magnetometer samples and %0d mean heading words,",
			ledger.samples_taken, ledger.headings_seen);
		$display("with %0d sample count settings and three idle patterns.", settings_written);
		if (ledger.mismatches == 0) begin
			$display("compass_heading_averager regression: pass");
		end else begin
			$display("compass_heading_averager regression: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/cha_pkg.sv
src/compass_heading_averager.sv
tb/compass_heading_averager_tb.sv
